/* rtl/u8vpl_pkg.sv */
`timescale 1ns / 1ps

package u8vpl_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] prefix_length;
    logic [1:0]  stop_cause;
  } out_item_t;

  // stop causes
  localparam logic [1:0] CAUSE_END       = 2'd0;
  localparam logic [1:0] CAUSE_INVALID   = 2'd1;
  localparam logic [1:0] CAUSE_LIMIT     = 2'd2;
  localparam logic [1:0] CAUSE_TRUNCATED = 2'd3;

  // second-byte range class of an open character
  localparam logic [2:0] LEAD_ANY = 3'd0;  // 80..BF
  localparam logic [2:0] LEAD_E0  = 3'd1;  // A0..BF
  localparam logic [2:0] LEAD_ED  = 3'd2;  // 80..9F
  localparam logic [2:0] LEAD_F0  = 3'd3;  // 90..BF
  localparam logic [2:0] LEAD_F4  = 3'd4;  // 80..8F

  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_ASCII   = 8'h80;
  localparam logic [7:0] BYTE_2_LO    = 8'hc2;
  localparam logic [7:0] BYTE_2_HI    = 8'hdf;
  localparam logic [7:0] BYTE_E0      = 8'he0;
  localparam logic [7:0] BYTE_ED      = 8'hed;
  localparam logic [7:0] BYTE_3_HI    = 8'hef;
  localparam logic [7:0] BYTE_F0      = 8'hf0;
  localparam logic [7:0] BYTE_F4      = 8'hf4;
  localparam logic [7:0] CONT_LO      = 8'h80;
  localparam logic [7:0] CONT_HI      = 8'hbf;
  localparam logic [7:0] CONT_E0_LO   = 8'ha0;
  localparam logic [7:0] CONT_ED_HI   = 8'h9f;
  localparam logic [7:0] CONT_F0_LO   = 8'h90;
  localparam logic [7:0] CONT_F4_HI   = 8'h8f;

  localparam logic [15:0] LIMIT_RESET = 16'd32;

endpackage

/* rtl/utf8_valid_prefix_length.sv */
`timescale 1ns / 1ps

// UTF-8 valid prefix length.
// Input channel (in_valid / in_stall / in_data): one string byte per transfer,
// string_end set on the string's last byte. Result channel (out_valid /
// out_stall / out_data): one result per marked byte, carrying the length of
// the well-formed prefix and the stop cause. cfg_valid / cfg_ready / cfg_data
// writes byte_limit; cfg_ready is always high.
// Throughput: one byte per clock while no marked byte waits on a held result.
// Bytes go through an input register, then decode/check logic updates the
// string state and, on a marked byte, loads the result register that drives
// out_valid. When the receiver stalls, unmarked bytes keep flowing; only a
// marked byte waits in the input register until the held result is taken,
// and while it waits the input stalls.
// Synchronous reset (rst_n low) empties both registers, clears the string
// state and sets byte_limit to 32.
module utf8_valid_prefix_length (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u8vpl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u8vpl_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  logic                 in_vld_r;
  u8vpl_pkg::in_item_t  in_item_r;
  logic                 out_vld_r;
  u8vpl_pkg::out_item_t out_item_r;
  logic [15:0]          limit_r;

  logic [15:0] committed_r, committed_nxt;
  logic [1:0]  cont_left_r, cont_left_nxt;
  logic [2:0]  pending_r, pending_nxt;
  logic [2:0]  lead_class_r, lead_class_nxt;
  logic        stopped_r, stopped_nxt;
  logic [1:0]  reason_r, reason_nxt;

  logic        consume;
  logic        in_load;
  logic [7:0]  b;
  logic [2:0]  width;
  logic [2:0]  cls;
  logic [16:0] end_pos;
  logic [7:0]  lo, hi;
  logic [2:0]  pend_inc;
  logic [1:0]  cause;

  // a marked byte may not advance while a result is held
  assign consume  = in_vld_r && !(in_item_r.string_end && out_vld_r && out_stall);
  assign in_stall = in_vld_r && !consume;
  assign in_load  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;
  assign b = in_item_r.text_byte;

  always_comb begin
    width = 3'd0;
    cls   = u8vpl_pkg::LEAD_ANY;
    if (b < u8vpl_pkg::BYTE_ASCII) begin
      width = 3'd1;
    end else if (b >= u8vpl_pkg::BYTE_2_LO && b <= u8vpl_pkg::BYTE_2_HI) begin
      width = 3'd2;
    end else if (b == u8vpl_pkg::BYTE_E0) begin
      width = 3'd3;
      cls   = u8vpl_pkg::LEAD_E0;
    end else if (b == u8vpl_pkg::BYTE_ED) begin
      width = 3'd3;
      cls   = u8vpl_pkg::LEAD_ED;
    end else if (b > u8vpl_pkg::BYTE_E0 && b <= u8vpl_pkg::BYTE_3_HI) begin
      width = 3'd3;
    end else if (b == u8vpl_pkg::BYTE_F0) begin
      width = 3'd4;
      cls   = u8vpl_pkg::LEAD_F0;
    end else if (b > u8vpl_pkg::BYTE_F0 && b < u8vpl_pkg::BYTE_F4) begin
      width = 3'd4;
    end else if (b == u8vpl_pkg::BYTE_F4) begin
      width = 3'd4;
      cls   = u8vpl_pkg::LEAD_F4;
    end
  end

  assign end_pos = {1'b0, committed_r} + {14'd0, width};

  always_comb begin
    lo = u8vpl_pkg::CONT_LO;
    hi = u8vpl_pkg::CONT_HI;
    if (pending_r == 3'd1) begin
      case (lead_class_r)
        u8vpl_pkg::LEAD_E0: lo = u8vpl_pkg::CONT_E0_LO;
        u8vpl_pkg::LEAD_ED: hi = u8vpl_pkg::CONT_ED_HI;
        u8vpl_pkg::LEAD_F0: lo = u8vpl_pkg::CONT_F0_LO;
        u8vpl_pkg::LEAD_F4: hi = u8vpl_pkg::CONT_F4_HI;
        default: ;
      endcase
    end
  end

  assign pend_inc = pending_r + 3'd1;

  always_comb begin
    committed_nxt  = committed_r;
    cont_left_nxt  = cont_left_r;
    pending_nxt    = pending_r;
    lead_class_nxt = lead_class_r;
    stopped_nxt    = stopped_r;
    reason_nxt     = reason_r;

    if (!stopped_r) begin
      if (cont_left_r == 2'd0) begin
        if (committed_r >= limit_r) begin
          stopped_nxt = 1'b1;
          reason_nxt  = u8vpl_pkg::CAUSE_LIMIT;
        end else if (b == u8vpl_pkg::BYTE_NUL) begin
          stopped_nxt = 1'b1;
          reason_nxt  = u8vpl_pkg::CAUSE_END;
        end else if (width == 3'd0) begin
          stopped_nxt = 1'b1;
          reason_nxt  = u8vpl_pkg::CAUSE_INVALID;
        end else if (end_pos > {1'b0, limit_r}) begin
          stopped_nxt = 1'b1;
          reason_nxt  = u8vpl_pkg::CAUSE_LIMIT;
        end else if (width == 3'd1) begin
          committed_nxt = committed_r + 16'd1;
        end else begin
          cont_left_nxt  = 2'(width - 3'd1);
          pending_nxt    = 3'd1;
          lead_class_nxt = cls;
        end
      end else begin
        if (b < lo || b > hi) begin
          stopped_nxt    = 1'b1;
          reason_nxt     = u8vpl_pkg::CAUSE_INVALID;
          cont_left_nxt  = 2'd0;
          pending_nxt    = 3'd0;
          lead_class_nxt = u8vpl_pkg::LEAD_ANY;
        end else if (cont_left_r == 2'd1) begin
          committed_nxt  = committed_r + {13'd0, pend_inc};
          cont_left_nxt  = 2'd0;
          pending_nxt    = 3'd0;
          lead_class_nxt = u8vpl_pkg::LEAD_ANY;
        end else begin
          cont_left_nxt = cont_left_r - 2'd1;
          pending_nxt   = pend_inc;
        end
      end
    end

    if (stopped_nxt) cause = reason_nxt;
    else if (cont_left_nxt != 2'd0) cause = u8vpl_pkg::CAUSE_TRUNCATED;
    else cause = u8vpl_pkg::CAUSE_END;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      limit_r      <= u8vpl_pkg::LIMIT_RESET;
      committed_r  <= '0;
      cont_left_r  <= '0;
      pending_r    <= '0;
      lead_class_r <= u8vpl_pkg::LEAD_ANY;
      stopped_r    <= 1'b0;
      reason_r     <= u8vpl_pkg::CAUSE_END;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;

      if (in_load) in_vld_r <= 1'b1;
      else if (consume) in_vld_r <= 1'b0;

      if (consume && in_item_r.string_end) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;

      if (consume) begin
        if (in_item_r.string_end) begin
          committed_r  <= '0;
          cont_left_r  <= '0;
          pending_r    <= '0;
          lead_class_r <= u8vpl_pkg::LEAD_ANY;
          stopped_r    <= 1'b0;
          reason_r     <= u8vpl_pkg::CAUSE_END;
        end else begin
          committed_r  <= committed_nxt;
          cont_left_r  <= cont_left_nxt;
          pending_r    <= pending_nxt;
          lead_class_r <= lead_class_nxt;
          stopped_r    <= stopped_nxt;
          reason_r     <= reason_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) in_item_r <= in_data;
    if (consume && in_item_r.string_end) begin
      out_item_r.prefix_length <= committed_nxt;
      out_item_r.stop_cause    <= cause;
    end
  end

endmodule

/* rtl/u8vpl_chk.sv */
`timescale 1ns / 1ps

module u8vpl_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input u8vpl_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input u8vpl_pkg::out_item_t out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held result changed or dropped");

  // marked byte passes the input register, then sets the result register if unblocked
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.string_end) ##1 !out_stall |=> out_valid)
    else $error("result missing after marked byte");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind utf8_valid_prefix_length u8vpl_chk u_chk (.*);
